FILE: rtl/mmcv_pkg.sv
// shared types and constants for the multi-method check verifier
package mmcv_pkg;

    // method register codes
    localparam logic [2:0] METHOD_CRC16    = 3'd0;
    localparam logic [2:0] METHOD_PARITY   = 3'd1;
    localparam logic [2:0] METHOD_CHECKSUM = 3'd2;
    localparam logic [2:0] METHOD_PARITY2D = 3'd3;
    localparam logic [2:0] METHOD_HAMMING  = 3'd4;

    // check constants
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;
    localparam logic [15:0] UNKNOWN_CODE = 16'hFFFF;
    localparam logic [15:0] POS_INIT     = 16'h0001;
    localparam logic [7:0]  BYTE_ONES    = 8'hFF;

    // input word: one packet byte
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [15:0] expected_code;
    } in_word_t;

    // output word: check result of one packet
    typedef struct packed {
        logic [15:0] computed_code;
        logic        code_matches;
    } out_word_t;

endpackage

FILE: rtl/multi_method_check_verifier.sv
// top level: input register, check accumulators, result register
//
//  channel  | signals                    | word
//  ---------+----------------------------+-------------------------------------
//  in       | in_valid / in_ready        | in_word: data_byte, last_byte, expected_code
//  out      | out_valid / out_ready      | out_word: computed_code, code_matches
//  cfg      | cfg_we                     | cfg_wdata: method (3 bits)
//
//  one byte per cycle unless input is held up; a byte waits in the input register and its
//  result (last byte only) is written to the result register as the byte moves on.
//  reset clears all checks (crc to 0xFFFF, bit position to 1) and method to 0.
//  only a last byte waiting on a full, stalled result register holds up input.
module multi_method_check_verifier
    import mmcv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_word_t   in_word,
    output logic       out_valid,
    input  logic       out_ready,
    output out_word_t  out_word,
    input  logic       cfg_we,
    input  logic [2:0] cfg_wdata
);

    logic      in_valid_reg;
    in_word_t  in_word_reg;
    logic      out_valid_reg;
    out_word_t out_word_reg;
    logic [2:0] method_reg;
    logic      advance;
    out_word_t result;

    // the held byte moves on unless it needs a result slot that is busy
    assign advance  = in_valid_reg
                      && (!in_word_reg.last_byte || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // method register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            method_reg <= METHOD_CRC16;
        else if (cfg_we)
            method_reg <= cfg_wdata;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_word_reg <= in_word;
    end

    // check accumulators
    mmcv_accum u_accum (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .word   (in_word_reg),
        .method (method_reg),
        .result (result)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && in_word_reg.last_byte)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_word_reg.last_byte)
            out_word_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // input stalls only behind a last byte blocked by a full result register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (in_valid_reg && in_word_reg.last_byte && out_valid_reg && !out_ready))
        else $error("input stalled without a blocked last byte");

    // a processed last byte always shows up as a result
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_word_reg.last_byte) |=> out_valid_reg)
        else $error("last byte produced no result");

    // a waiting result is never dropped
    a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg)
        else $error("pending result lost");

endmodule

FILE: rtl/mmcv_accum.sv
// running check accumulators and selection of the check value
module mmcv_accum
    import mmcv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  in_word_t  word,
    input  logic [2:0] method,
    output out_word_t result
);

    logic [15:0] crc_reg;
    logic        parity_reg;
    logic [15:0] sum_reg;
    logic [7:0]  held_reg;
    logic        pending_reg;
    logic [7:0]  xor_reg;
    logic [15:0] sig_reg;
    logic [15:0] pos_reg;

    logic [15:0] crc_next;
    logic        parity_next;
    logic [15:0] sum_next;
    logic [7:0]  held_next;
    logic        pending_next;
    logic [7:0]  xor_next;
    logic [15:0] sig_next;
    logic [15:0] pos_next;

    logic [15:0] addend;
    logic [16:0] sum_raw;
    logic [15:0] sum_wrap;
    logic [15:0] code;

    // crc-16 update over one byte, reflected, lsb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    // crc, parity, 2d parity and position signature
    always_comb
    begin
        crc_next    = crc_byte(crc_reg, word.data_byte);
        parity_next = parity_reg ^ (^word.data_byte);
        xor_next    = xor_reg ^ word.data_byte;
        sig_next    = sig_reg;
        for (int j = 0; j < 8; j++)
        begin
            if (word.data_byte[j])
                sig_next = sig_next ^ (pos_reg + 16'(j));
        end
        pos_next = pos_reg + 16'd8;
    end

    // internet checksum: pair bytes, low byte first, end-around carry
    always_comb
    begin
        held_next    = held_reg;
        pending_next = pending_reg;
        addend       = 16'h0000;
        if (pending_reg)
        begin
            addend       = {word.data_byte, held_reg};
            held_next    = 8'h00;
            pending_next = 1'b0;
        end
        else if (word.last_byte)
        begin
            addend = {8'h00, word.data_byte};
        end
        else
        begin
            held_next    = word.data_byte;
            pending_next = 1'b1;
        end
        sum_raw  = {1'b0, sum_reg} + {1'b0, addend};
        sum_wrap = sum_raw[15:0] + {15'd0, sum_raw[16]};
        if (pending_reg || word.last_byte)
            sum_next = sum_wrap;
        else
            sum_next = sum_reg;
    end

    // selected check value over the packet including this byte
    always_comb
    begin
        unique case (method)
            METHOD_CRC16:    code = crc_next;
            METHOD_PARITY:   code = {15'd0, parity_next};
            METHOD_CHECKSUM: code = ~sum_next;
            METHOD_PARITY2D: code = {xor_next, xor_next ^ BYTE_ONES};
            METHOD_HAMMING:  code = sig_next;
            default:         code = UNKNOWN_CODE;
        endcase
        result.computed_code = code;
        result.code_matches  = (code == word.expected_code);
    end

    // accumulator registers, cleared after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg     <= CRC_INIT;
            parity_reg  <= 1'b0;
            sum_reg     <= 16'h0000;
            held_reg    <= 8'h00;
            pending_reg <= 1'b0;
            xor_reg     <= 8'h00;
            sig_reg     <= 16'h0000;
            pos_reg     <= POS_INIT;
        end
        else if (step)
        begin
            if (word.last_byte)
            begin
                crc_reg     <= CRC_INIT;
                parity_reg  <= 1'b0;
                sum_reg     <= 16'h0000;
                held_reg    <= 8'h00;
                pending_reg <= 1'b0;
                xor_reg     <= 8'h00;
                sig_reg     <= 16'h0000;
                pos_reg     <= POS_INIT;
            end
            else
            begin
                crc_reg     <= crc_next;
                parity_reg  <= parity_next;
                sum_reg     <= sum_next;
                held_reg    <= held_next;
                pending_reg <= pending_next;
                xor_reg     <= xor_next;
                sig_reg     <= sig_next;
                pos_reg     <= pos_next;
            end
        end
    end

endmodule

FILE: bench/mmcv_code_checker.sv
`timescale 1ns / 1ps
// checker for the multi-method check verifier: mirrors the five checks and compares result words
module mmcv_code_checker
    import mmcv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  in_word_t   in_word,
    input  logic       out_valid,
    input  logic       out_ready,
    input  out_word_t  out_word,
    input  logic       cfg_we,
    input  logic [2:0] cfg_wdata,
    output int         fail_count,
    output int         outstanding,
    output int         results_checked
);

    localparam int MAX_REPORTS = 10;

    // mirrored method register and running checks
    logic [2:0]  method;
    logic [15:0] crc_acc;
    logic        parity_acc;
    logic [15:0] csum_acc;
    logic [7:0]  low_held;
    logic        low_pending;
    logic [7:0]  xor_acc;
    logic [15:0] pos_sig;
    logic [15:0] pos_next;

    // result words still owed by the block, oldest first
    out_word_t expected_words[$];

    // ones' complement add with end-around carry
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    // back to the start-of-packet values
    task automatic clear_checks();
        crc_acc     = CRC_INIT;
        parity_acc  = 1'b0;
        csum_acc    = 16'd0;
        low_held    = 8'd0;
        low_pending = 1'b0;
        xor_acc     = 8'd0;
        pos_sig     = 16'd0;
        pos_next    = POS_INIT;
    endtask

    // fold one data byte into every check
    task automatic fold_byte(input logic [7:0] b, input logic last);
        logic [15:0] c;
        int          j;
        c = crc_acc ^ {8'd0, b};
        for (j = 0; j < 8; j++)
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        crc_acc = c;

        // parity and position signature over set bits
        for (j = 0; j < 8; j++)
        begin
            if (b[j])
            begin
                parity_acc = ~parity_acc;
                pos_sig    = pos_sig ^ (pos_next + 16'(j));
            end
        end
        pos_next = pos_next + 16'd8;

        // little-endian word pairing, odd tail byte goes in low
        if (low_pending)
        begin
            csum_acc    = ones_add(csum_acc, {b, low_held});
            low_pending = 1'b0;
            low_held    = 8'd0;
        end
        else if (last)
            csum_acc = ones_add(csum_acc, {8'd0, b});
        else
        begin
            low_held    = b;
            low_pending = 1'b1;
        end

        xor_acc = xor_acc ^ b;
    endtask

    // value of the selected check
    function automatic logic [15:0] packet_code();
        case (method)
            METHOD_CRC16:    return crc_acc;
            METHOD_PARITY:   return {15'd0, parity_acc};
            METHOD_CHECKSUM: return ~csum_acc;
            METHOD_PARITY2D: return {xor_acc, xor_acc ^ BYTE_ONES};
            METHOD_HAMMING:  return pos_sig;
            default:         return UNKNOWN_CODE;
        endcase
    endfunction

    task automatic flag_error(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t mismatch: %s", $time, msg);
    endtask

    // watch the channels; results are taken before new words so order holds
    always @(posedge clk or negedge rst_n)
    begin : monitor
        out_word_t want;
        if (!rst_n)
        begin
            method = METHOD_CRC16;
            clear_checks();
            expected_words.delete();
            outstanding = 0;
        end
        else
        begin
            // result word leaving the block
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                    flag_error($sformatf("result word with none expected: code %h match %b",
                                         out_word.computed_code, out_word.code_matches));
                else
                begin
                    want = expected_words.pop_front();
                    results_checked++;
                    if (out_word.computed_code !== want.computed_code)
                        flag_error($sformatf("computed_code expected %h got %h",
                                             want.computed_code, out_word.computed_code));
                    if (out_word.code_matches !== want.code_matches)
                        flag_error($sformatf("code_matches expected %b got %b (code %h)",
                                             want.code_matches, out_word.code_matches,
                                             want.computed_code));
                end
            end

            // data word entering the block
            if (in_valid && in_ready)
            begin
                fold_byte(in_word.data_byte, in_word.last_byte);
                if (in_word.last_byte)
                begin
                    want.computed_code = packet_code();
                    want.code_matches  = (want.computed_code == in_word.expected_code);
                    expected_words.push_back(want);
                    clear_checks();
                end
            end

            if (cfg_we)
                method = cfg_wdata;
            outstanding = expected_words.size();
        end
    end

endmodule

FILE: bench/multi_method_check_verifier_tb.sv
`timescale 1ns / 1ps
// testbench top for the multi-method check verifier: clock, reset, stimulus and verdict
module multi_method_check_verifier_tb;
    import mmcv_pkg::*;

    localparam int         MAX_GAP          = 15;
    localparam int         HOLD_CYCLES      = 64;
    localparam int         SETTLE_CYCLES    = 4;
    localparam int         END_CYCLES       = 8;
    localparam int         WATCHDOG_LIMIT   = 2000;
    localparam int         RANDOM_BYTES     = 320;
    localparam int         LONG_BYTES       = 48;
    localparam logic [2:0] METHOD_UNDEF_LOW = 3'd5;
    localparam logic [2:0] METHOD_UNDEF_TOP = 3'd7;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    in_word_t   in_word;
    logic       out_valid;
    logic       out_ready;
    out_word_t  out_word;
    logic       cfg_we;
    logic [2:0] cfg_wdata;

    int fail_count;
    int outstanding;
    int results_checked;

    // stimulus bookkeeping
    logic [7:0]  pkt_bytes[$];
    logic [15:0] last_code;
    logic [7:0]  method_mask = 8'd0;
    bit          gaps_on;
    bit          stall_on;
    bit          hold_request;
    int          bytes_sent;
    int          packets_sent;
    int          packets_resent;

    always #4 clk = ~clk;

    multi_method_check_verifier dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    mmcv_code_checker code_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_word         (in_word),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_word        (out_word),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    // offer one word after an optional gap and wait until it is taken
    task automatic send_word(input logic [7:0] b, input logic last, input logic [15:0] code);
        in_word_t w;
        int       gap;
        w.data_byte     = b;
        w.last_byte     = last;
        w.expected_code = code;
        gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (!(in_valid && in_ready)) @(posedge clk);
        bytes_sent++;
    endtask

    // whole packet, the code rides on every word
    task automatic send_pkt(input logic [15:0] code);
        foreach (pkt_bytes[i])
            send_word(pkt_bytes[i], i == pkt_bytes.size() - 1, code);
        packets_sent++;
    endtask

    // stop offering and wait for every owed result plus pipeline settle
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // method write while the block is idle
    task automatic set_method(input logic [2:0] m);
        drain();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(negedge clk);
        cfg_we    <= 1'b0;
        method_mask[m] = 1'b1;
    endtask

    // random bytes with extra weight on all-zero and all-one
    task automatic fill_random_pkt(input int len);
        int k;
        pkt_bytes.delete();
        for (k = 0; k < len; k++)
        begin
            case ($urandom_range(0, 7))
                0:       pkt_bytes.push_back(8'h00);
                1:       pkt_bytes.push_back(8'hFF);
                default: pkt_bytes.push_back(8'($urandom));
            endcase
        end
    endtask

    function automatic logic [15:0] random_code();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(0, 1));
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // result side: random stalls, one long hold-off on request
    initial
    begin : receiver
        int gap;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_request)
            begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            gap = stall_on ? $urandom_range(0, MAX_GAP) : 0;
            if (gap > 0)
            begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            out_ready <= 1'b1;
            @(posedge clk);
            while (!(out_valid && out_ready)) @(posedge clk);
            last_code = out_word.computed_code;
        end
    end

    // no word moving on either channel for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (rst_n !== 1'b1 || (in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("multi_method_check_verifier verification failed");
        $finish;
    end

    initial
    begin : stimulus
        int len;
        int random_goal;
        bit have_pkt;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_word   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = METHOD_CRC16;
        gaps_on   = 1'b0;
        stall_on  = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // crc of ascii 1..9 under the reset method
        pkt_bytes = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39};
        send_pkt(16'h4B37);

        // single-byte packet, even number of ones
        set_method(METHOD_PARITY);
        pkt_bytes = '{8'hFF};
        send_pkt(16'h0000);

        // odd length with a zero byte, tail goes in as low byte
        set_method(METHOD_CHECKSUM);
        pkt_bytes = '{8'h00, 8'hFF, 8'h80};
        send_pkt(16'h007F);

        set_method(METHOD_PARITY2D);
        pkt_bytes = '{8'hA5, 8'h5A};
        send_pkt(16'hFF00);

        // first and sixteenth bit positions
        set_method(METHOD_HAMMING);
        pkt_bytes = '{8'h01, 8'h80};
        send_pkt(16'h0011);

        // unknown methods
        set_method(METHOD_UNDEF_LOW);
        pkt_bytes = '{8'h00};
        send_pkt(16'hFFFF);
        set_method(METHOD_UNDEF_TOP);
        pkt_bytes = '{8'hFF};
        send_pkt(16'h0000);

        // method changed in the middle of a packet
        set_method(METHOD_CRC16);
        send_word(8'h12, 1'b0, 16'h5555);
        send_word(8'h34, 1'b0, 16'hAAAA);
        set_method(METHOD_CHECKSUM);
        send_word(8'h56, 1'b1, 16'hFFFF);
        packets_sent++;

        // receiver holds off while single-byte packets keep coming
        drain();
        hold_request = 1'b1;
        repeat (24)
        begin
            pkt_bytes = '{8'($urandom)};
            send_pkt(random_code());
        end

        // random packets, method changed between phases
        random_goal = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < random_goal)
        begin
            gaps_on  = ($urandom_range(0, 3) != 0);
            stall_on = ($urandom_range(0, 3) != 0);
            set_method(3'($urandom_range(0, 7)));
            have_pkt = 1'b0;
            repeat ($urandom_range(3, 8))
            begin
                if (have_pkt && $urandom_range(0, 3) == 0)
                begin
                    // resend the last packet with the code it produced
                    drain();
                    send_pkt(last_code);
                    packets_resent++;
                end
                else
                begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                      : $urandom_range(1, 6);
                    fill_random_pkt(len);
                    send_pkt(random_code());
                end
                have_pkt = 1'b1;
            end
        end

        // one longer packet through the position signature
        gaps_on  = 1'b0;
        stall_on = 1'b0;
        set_method(METHOD_HAMMING);
        fill_random_pkt(LONG_BYTES);
        send_pkt(random_code());

        drain();
        repeat (END_CYCLES) @(negedge clk);
        $display("run covered %0d bytes in %0d packets (%0d resent with their own code)",
                 bytes_sent, packets_sent, packets_resent);
        $display("%0d results checked, methods written (one bit per code): %b",
                 results_checked, method_mask);
        if (fail_count == 0 && outstanding == 0)
            $display("multi_method_check_verifier verification clean");
        else
            $display("multi_method_check_verifier verification failed");
        $finish;
    end

endmodule
